FILE: design/abdf_pkg.sv
// Package for the anchor box decode and filter unit.
// Types, sizes, constants and arithmetic helpers used by the top level, abdf_cfg and abdf_decode.
// No dependencies.
package abdf_pkg;

  // Template table
  localparam int TEMPLATE_SLOTS = 32;
  localparam int SLOT_AW        = (TEMPLATE_SLOTS > 1) ? $clog2(TEMPLATE_SLOTS) : 1;
  localparam int TBL_W          = 32;

  // Grid
  localparam int GRID_MAX  = 512;
  localparam int CELL_SIZE = 8;

  // Action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // Configuration registers, index = paddr[APB_AW-1:2]
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  typedef enum logic [1:0] {
    REG_SCORE_THRESHOLD = 2'd0,
    REG_FRAME_WIDTH     = 2'd1,
    REG_FRAME_HEIGHT    = 2'd2
  } reg_idx_e;

  localparam logic [15:0] THRESHOLD_RST = 16'd0;
  localparam logic [11:0] FRAME_W_RST   = 12'd224;
  localparam logic [11:0] FRAME_H_RST   = 12'd224;

  typedef struct packed {
    logic [15:0] score_threshold;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
  } cfg_t;

  // Arithmetic widths
  localparam int EXP_W   = 17;  // d*log2(e), Q4.12
  localparam int MANT_W  = 17;  // 2^frac, Q.16
  localparam int PROD_W  = 34;  // size * mantissa
  localparam int SIZE_W  = 20;  // saturated size, Q16.4
  localparam int CW      = 22;  // centre, Q17.4 signed
  localparam int CRN_W   = CW + 2;  // corners, Q.5 signed
  localparam int SIZE_SAT = 1048575;
  localparam int LOG2E_Q16 = 94548;

  // 2^(i/16) in Q.16
  localparam logic [17:0] POW2_FRAC [17] = '{
    18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
    18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
    18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
  };

  typedef struct packed {
    logic                we;
    logic [SLOT_AW-1:0]  waddr;
    logic [TBL_W-1:0]    wdata;
    logic                re;
    logic [SLOT_AW-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic              neg;
    logic [SIZE_W-1:0] mag;
  } size_t;

  // floor((d*log2(e) in Q.16 + half) / 2^16)
  function automatic logic signed [EXP_W-1:0] log2e_scale(input logic signed [15:0] d);
    logic signed [33:0] p;
    p = $signed({{18{d[15]}}, d}) * 34'sd94548 + 34'sd32768;
    return p[32:16];
  endfunction

  // Piecewise linear 2^(x/4096) for x in [0,4096), Q.16
  function automatic logic [MANT_W-1:0] pow2_mant(input logic [3:0] idx,
                                                  input logic [7:0] frac);
    logic [17:0] lo;
    logic [17:0] hi;
    logic [12:0] diff;
    logic [20:0] step;
    lo   = POW2_FRAC[5'(idx)];
    hi   = POW2_FRAC[5'(idx) + 5'd1];
    diff = 13'(hi - lo);
    step = 21'(diff) * 21'(frac) + 21'd128;
    return MANT_W'(lo) + MANT_W'(step[20:8]);
  endfunction

  // floor((p + 2^(s-1)) / 2^s), saturated above
  function automatic size_t size_round(input logic signed [PROD_W-1:0] p,
                                       input logic [4:0] s);
    logic signed [PROD_W:0] sum;
    logic signed [PROD_W:0] q;
    size_t r;
    sum   = {p[PROD_W-1], p} + ((PROD_W+1)'(1) << (s - 5'd1));
    q     = sum >>> s;
    r.neg = q[PROD_W];
    r.mag = (q[PROD_W-1:0] > PROD_W'(SIZE_SAT)) ? SIZE_W'(SIZE_SAT) : q[SIZE_W-1:0];
    return r;
  endfunction

endpackage

FILE: design/abdf_channels.sv
// Valid/ready channel interfaces of the anchor box decode and filter unit.
// abdf_in_if carries load and decode items, abdf_out_if carries kept boxes.
// No dependencies.
interface abdf_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [4:0]         template_index;
  logic signed [15:0] template_width;
  logic signed [15:0] template_height;
  logic [8:0]         cell_x;
  logic [8:0]         cell_y;
  logic [15:0]        confidence;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic signed [15:0] delta_w;
  logic signed [15:0] delta_h;

  modport source (
    output valid, action, template_index, template_width, template_height,
           cell_x, cell_y, confidence, delta_x, delta_y, delta_w, delta_h,
    input  ready
  );
  modport sink (
    input  valid, action, template_index, template_width, template_height,
           cell_x, cell_y, confidence, delta_x, delta_y, delta_w, delta_h,
    output ready
  );
endinterface

interface abdf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] box_left;
  logic [15:0] box_top;
  logic [15:0] box_right;
  logic [15:0] box_bottom;
  logic [15:0] box_score;

  modport source (
    output valid, box_left, box_top, box_right, box_bottom, box_score,
    input  ready
  );
  modport sink (
    input  valid, box_left, box_top, box_right, box_bottom, box_score,
    output ready
  );
endinterface

FILE: design/anchor_box_decode_filter_unit.sv
// Anchor box decode and filter, top level. A kept box passes stages 1 to 4
// and then the output register. Throughput: one item per cycle while the
// output is not stalled. Each item reads the template table; a load also writes
// it. Stages that hold no item never stall the input. Reset clears all stage valid
// bits and loads threshold 0 and frame 224x224; the template table is not
// cleared and holds no defined value until a load writes the slot.
module anchor_box_decode_filter_unit
  import abdf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  abdf_in_if.sink           in_i,
  abdf_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t             cfg;
  ram_req_t         ram_req;
  logic [TBL_W-1:0] ram_rdata;

  abdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  abdf_ram #(
    .W     (TBL_W),
    .DEPTH (TEMPLATE_SLOTS)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  abdf_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Input backpressure only comes from a full pipe behind a stalled output
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output backpressure");

  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.box_left <= out_o.box_right)
                    && (out_o.box_top <= out_o.box_bottom))
    else $error("box corners out of order");

  a_inside_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.box_right <= {cfg.frame_width, 4'b0})
                    && (out_o.box_bottom <= {cfg.frame_height, 4'b0}))
    else $error("kept box reaches outside the frame");

  a_score_threshold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.box_score >= cfg.score_threshold))
    else $error("kept box below score threshold");

endmodule

FILE: design/abdf_ram.sv
// Generic single-port-per-direction RAM: one write and one registered read per cycle.
// No dependencies.
module abdf_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/abdf_cfg.sv
// APB-style configuration registers: score threshold and frame size.
// Depends on abdf_pkg.
module abdf_cfg
  import abdf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SCORE_THRESHOLD: cfg_d.score_threshold = pwdata[15:0];
        REG_FRAME_WIDTH:     cfg_d.frame_width     = pwdata[11:0];
        REG_FRAME_HEIGHT:    cfg_d.frame_height    = pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCORE_THRESHOLD: prdata = APB_DW'(cfg_q.score_threshold);
      REG_FRAME_WIDTH:     prdata = APB_DW'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:    prdata = APB_DW'(cfg_q.frame_height);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold <= THRESHOLD_RST;
      cfg_q.frame_width     <= FRAME_W_RST;
      cfg_q.frame_height    <= FRAME_H_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/abdf_decode.sv
// Decode pipeline: template table access, exp scaling, centre and corner
// computation, frame filter and output register.
// Depends on abdf_pkg and abdf_channels; the template RAM sits outside.
module abdf_decode
  import abdf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  abdf_in_if.sink           in_i,
  abdf_out_if.source        out_o,
  output ram_req_t          ram_req_o,
  input  logic [TBL_W-1:0]  ram_rdata_i
);

  // Stage enables, a stage loads when it is empty or its successor moves
  logic en1, en2, en3, en4, en_out;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic accept, pass0;

  assign en_out = !out_valid_q || out_o.ready;
  assign en4    = !v4_q || en_out;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;

  assign in_i.ready = en1;
  assign accept     = in_i.valid && en1;

  // Loads write the table at transfer; every item reads it. The write lands before
  // a later item reads, so a decode right after a load of the same slot sees the new entry.
  always_comb begin
    ram_req_o.we    = accept && (in_i.action == ACT_LOAD)
                      && (32'(in_i.template_index) < TEMPLATE_SLOTS);
    ram_req_o.waddr = SLOT_AW'(in_i.template_index);
    ram_req_o.wdata = {in_i.template_height, in_i.template_width};
    ram_req_o.re    = en1;
    ram_req_o.raddr = SLOT_AW'(in_i.template_index);
  end

  assign pass0 = (in_i.action == ACT_DECODE)
                 && (32'(in_i.template_index) < TEMPLATE_SLOTS)
                 && (32'(in_i.cell_x) < GRID_MAX)
                 && (32'(in_i.cell_y) < GRID_MAX)
                 && (in_i.confidence >= cfg_i.score_threshold);

  // ---------------- stage 1: table read, log2 scaling
  logic [8:0]               cx1_q, cy1_q;
  logic [15:0]              conf1_q;
  logic signed [15:0]       dx1_q, dy1_q;
  logic signed [EXP_W-1:0]  yw1_q, yh1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cx1_q   <= in_i.cell_x;
      cy1_q   <= in_i.cell_y;
      conf1_q <= in_i.confidence;
      dx1_q   <= in_i.delta_x;
      dy1_q   <= in_i.delta_y;
      yw1_q   <= log2e_scale(in_i.delta_w);
      yh1_q   <= log2e_scale(in_i.delta_h);
    end
  end

  // ---------------- stage 2: offset products, mantissas, shift counts
  logic signed [15:0] tw1, th1;
  logic signed [5:0]  kw1, kh1;
  logic [4:0]         sw1, sh1;

  assign tw1 = ram_rdata_i[15:0];
  assign th1 = ram_rdata_i[31:16];
  // y = 4096*k + f, shift s = 16 - k in 5..28
  assign kw1 = {yw1_q[EXP_W-1], yw1_q[EXP_W-1:12]};
  assign kh1 = {yh1_q[EXP_W-1], yh1_q[EXP_W-1:12]};
  assign sw1 = 5'(6'sd16 - kw1);
  assign sh1 = 5'(6'sd16 - kh1);

  logic [8:0]          cx2_q, cy2_q;
  logic [15:0]         conf2_q;
  logic signed [31:0]  pcx2_q, pcy2_q;
  logic signed [15:0]  tw2_q, th2_q;
  logic [MANT_W-1:0]   mw2_q, mh2_q;
  logic [4:0]          sw2_q, sh2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;
      conf2_q <= conf1_q;
      pcx2_q  <= 32'(tw1) * 32'(dx1_q);
      pcy2_q  <= 32'(th1) * 32'(dy1_q);
      tw2_q   <= tw1;
      th2_q   <= th1;
      mw2_q   <= pow2_mant(yw1_q[11:8], yw1_q[7:0]);
      mh2_q   <= pow2_mant(yh1_q[11:8], yh1_q[7:0]);
      sw2_q   <= sw1;
      sh2_q   <= sh1;
    end
  end

  // ---------------- stage 3: centres, size products
  logic signed [32:0] rcx2, rcy2;
  logic signed [CW-1:0] bx2, by2, cx2, cy2;

  assign rcx2 = 33'(pcx2_q) + 33'sd2048;
  assign rcy2 = 33'(pcy2_q) + 33'sd2048;
  // (cell*CELL_SIZE - 2) in Q12.4
  assign bx2  = $signed(CW'(cx2_q) * CW'(CELL_SIZE * 16)) - CW'(32);
  assign by2  = $signed(CW'(cy2_q) * CW'(CELL_SIZE * 16)) - CW'(32);
  assign cx2  = bx2 + CW'($signed(rcx2[32:12]));
  assign cy2  = by2 + CW'($signed(rcy2[32:12]));

  logic [15:0]               conf3_q;
  logic signed [CW-1:0]      cx3_q, cy3_q;
  logic signed [PROD_W-1:0]  pw3_q, ph3_q;
  logic [4:0]                sw3_q, sh3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      conf3_q <= conf2_q;
      cx3_q   <= cx2;
      cy3_q   <= cy2;
      pw3_q   <= PROD_W'(tw2_q) * PROD_W'($signed({1'b0, mw2_q}));
      ph3_q   <= PROD_W'(th2_q) * PROD_W'($signed({1'b0, mh2_q}));
      sw3_q   <= sw2_q;
      sh3_q   <= sh2_q;
    end
  end

  // ---------------- stage 4: rounding shift and saturation
  size_t w3, h3;
  assign w3 = size_round(pw3_q, sw3_q);
  assign h3 = size_round(ph3_q, sh3_q);

  logic [15:0]           conf4_q;
  logic signed [CW-1:0]  cx4_q, cy4_q;
  logic [SIZE_W-1:0]     w4_q, h4_q;
  logic                  neg4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      conf4_q <= conf3_q;
      cx4_q   <= cx3_q;
      cy4_q   <= cy3_q;
      w4_q    <= w3.mag;
      h4_q    <= h3.mag;
      neg4_q  <= w3.neg || h3.neg;
    end
  end

  // ---------------- corners in Q.5, frame test, rounding to Q12.4
  logic signed [CRN_W-1:0] l2, r2, t2, b2, fw2, fh2;
  logic signed [CRN_W-1:0] l2r, r2r, t2r, b2r;
  logic                    keep4;

  assign l2  = (CRN_W'(cx4_q) <<< 1) - CRN_W'(w4_q);
  assign r2  = (CRN_W'(cx4_q) <<< 1) + CRN_W'(w4_q);
  assign t2  = (CRN_W'(cy4_q) <<< 1) - CRN_W'(h4_q);
  assign b2  = (CRN_W'(cy4_q) <<< 1) + CRN_W'(h4_q);
  assign fw2 = $signed(CRN_W'({cfg_i.frame_width, 5'b0}));
  assign fh2 = $signed(CRN_W'({cfg_i.frame_height, 5'b0}));
  assign l2r = l2 + CRN_W'(1);
  assign r2r = r2 + CRN_W'(1);
  assign t2r = t2 + CRN_W'(1);
  assign b2r = b2 + CRN_W'(1);

  assign keep4 = !neg4_q && (l2 >= 0) && (t2 >= 0) && (r2 <= fw2) && (b2 <= fh2);

  // ---------------- output register
  logic [15:0] left_q, top_q, right_q, bottom_q, score_q;

  always_ff @(posedge clk_i) begin
    if (en_out && v4_q) begin
      left_q   <= l2r[16:1];
      top_q    <= t2r[16:1];
      right_q  <= r2r[16:1];
      bottom_q <= b2r[16:1];
      score_q  <= conf4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= accept && pass0;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en4)    v4_q        <= v3_q;
      if (en_out) out_valid_q <= v4_q && keep4;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.box_left   = left_q;
  assign out_o.box_top    = top_q;
  assign out_o.box_right  = right_q;
  assign out_o.box_bottom = bottom_q;
  assign out_o.box_score  = score_q;

endmodule

FILE: sim/testbench.sv
// Testbench for anchor_box_decode_filter_unit: template loads, cell decodes and APB setup.
// A scoreboard class predicts kept boxes from the accepted items; plain tasks drive the block.
// Depends on design/abdf_pkg.sv, design/abdf_channels.sv and the unit itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import abdf_pkg::*;

  localparam int          CLK_PERIOD     = 10;
  localparam int          RESET_CYCLES   = 7;
  localparam int          SETTLE_CYCLES  = 8;   // pipeline is 5 deep
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [1:0]  REG_UNMAPPED   = 2'd3;

  typedef struct packed {
    logic               action;
    logic [4:0]         template_index;
    logic signed [15:0] template_width;
    logic signed [15:0] template_height;
    logic [8:0]         cell_x;
    logic [8:0]         cell_y;
    logic [15:0]        confidence;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] delta_w;
    logic signed [15:0] delta_h;
  } cell_item_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] score;
  } box_t;

  class box_scoreboard;
    logic [15:0] threshold = THRESHOLD_RST;
    logic [11:0] frame_w   = FRAME_W_RST;
    logic [11:0] frame_h   = FRAME_H_RST;
    logic [31:0] templates [TEMPLATE_SLOTS];
    box_t        boxes_due [$];
    int          errors = 0;
    int          reports = 0;
    int          boxes_seen = 0;
    int          loads = 0;
    int          decodes = 0;

    function void flag(string what);
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("ERROR @%0t: %s", $realtime, what);
      end
    endfunction

    function string box_str(box_t b);
      return $sformatf("l=%0d t=%0d r=%0d b=%0d s=%0d", b.left, b.top, b.right, b.bottom,
                       b.score);
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_SCORE_THRESHOLD: threshold = data[15:0];
        REG_FRAME_WIDTH:     frame_w   = data[11:0];
        REG_FRAME_HEIGHT:    frame_h   = data[11:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_SCORE_THRESHOLD: return 32'(threshold);
        REG_FRAME_WIDTH:     return 32'(frame_w);
        REG_FRAME_HEIGHT:    return 32'(frame_h);
        default:             return '0;
      endcase
    endfunction

    function void check_reg(logic [1:0] idx, logic [31:0] got);
      if (got !== reg_value(idx))
        flag($sformatf("register %0d read 0x%0h, expected 0x%0h", idx, got, reg_value(idx)));
    endfunction

    // size * 2^(d*log2(e)), piecewise linear mantissa, saturated
    function longint scaled_size(longint size, longint d);
      longint y, k, f, m, lo, hi, w;
      int     idx, s;
      y   = (d * LOG2E_Q16 + 32768) >>> 16;
      k   = y >>> 12;
      f   = y - k * 4096;
      idx = int'(f >> 8);
      lo  = POW2_FRAC[idx];
      hi  = POW2_FRAC[idx + 1];
      m   = lo + (((hi - lo) * (f & 255) + 128) >>> 8);
      s   = 16 - int'(k);
      w   = (size * m + (longint'(1) << (s - 1))) >>> s;
      return (w > SIZE_SAT) ? longint'(SIZE_SAT) : w;
    endfunction

    function void note_item(cell_item_t it);
      logic signed [15:0] tw16, th16;
      longint             tw, th, cx, cy, w, h, l2, t2, r2, b2;
      box_t               due;
      if (it.action == ACT_LOAD) begin
        loads++;
        if (it.template_index < TEMPLATE_SLOTS)
          templates[it.template_index] = {it.template_height, it.template_width};
        return;
      end
      decodes++;
      if (it.template_index >= TEMPLATE_SLOTS || it.cell_x >= GRID_MAX || it.cell_y >= GRID_MAX)
        return;
      if (it.confidence < threshold) return;
      tw16 = templates[it.template_index][15:0];
      th16 = templates[it.template_index][31:16];
      tw = tw16;
      th = th16;
      cx = (longint'(it.cell_x) * CELL_SIZE - 2) * 16 + ((tw * it.delta_x + 2048) >>> 12);
      cy = (longint'(it.cell_y) * CELL_SIZE - 2) * 16 + ((th * it.delta_y + 2048) >>> 12);
      w  = scaled_size(tw, it.delta_w);
      h  = scaled_size(th, it.delta_h);
      if (w < 0 || h < 0) return;
      // corners in Q.5
      l2 = 2 * cx - w;
      r2 = 2 * cx + w;
      t2 = 2 * cy - h;
      b2 = 2 * cy + h;
      if (l2 < 0 || t2 < 0 || r2 > longint'(frame_w) * 32 || b2 > longint'(frame_h) * 32)
        return;
      due = '{left:   16'((l2 + 1) >>> 1),
              top:    16'((t2 + 1) >>> 1),
              right:  16'((r2 + 1) >>> 1),
              bottom: 16'((b2 + 1) >>> 1),
              score:  it.confidence};
      boxes_due = {boxes_due, due};
    endfunction

    function void check_box(box_t got);
      box_t want;
      if (boxes_due.size() == 0) begin
        flag({"unexpected box ", box_str(got)});
        return;
      end
      want = boxes_due.pop_front();
      boxes_seen++;
      if (got.left !== want.left || got.top !== want.top || got.right !== want.right ||
          got.bottom !== want.bottom || got.score !== want.score)
        flag({"box mismatch: expected ", box_str(want), ", got ", box_str(got)});
    endfunction

    function int pending();
      return boxes_due.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  abdf_in_if  in_ch ();
  abdf_out_if out_ch ();

  anchor_box_decode_filter_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  box_scoreboard sb = new();
  bit            loaded [TEMPLATE_SLOTS];
  bit            gaps_on = 1'b0;
  int            stall_left = 0;
  int            settings_used = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result side: check every transfer, stall in random bursts while gaps_on is set
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_box('{left: out_ch.box_left, top: out_ch.box_top, right: out_ch.box_right,
                     bottom: out_ch.box_bottom, score: out_ch.box_score});
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (psel === 1'b1 && penable === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.write_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(logic [1:0] idx, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic readback_regs();
    logic [31:0] rd;
    for (int i = 0; i <= 2; i++) begin
      apb_read(2'(i), rd);
      sb.check_reg(2'(i), rd);
    end
  endtask

  // Always advances at least one edge, so valid never sees two updates in one step
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic configure(logic [15:0] thr, logic [11:0] fw, logic [11:0] fh);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_write(REG_SCORE_THRESHOLD, 32'(thr));
    apb_write(REG_FRAME_WIDTH, 32'(fw));
    apb_write(REG_FRAME_HEIGHT, 32'(fh));
    apb_write(REG_UNMAPPED, $urandom);
    readback_regs();
    settings_used++;
  endtask

  task automatic send_item(cell_item_t it);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= it.action;
    in_ch.template_index  <= it.template_index;
    in_ch.template_width  <= it.template_width;
    in_ch.template_height <= it.template_height;
    in_ch.cell_x          <= it.cell_x;
    in_ch.cell_y          <= it.cell_y;
    in_ch.confidence      <= it.confidence;
    in_ch.delta_x         <= it.delta_x;
    in_ch.delta_y         <= it.delta_y;
    in_ch.delta_w         <= it.delta_w;
    in_ch.delta_h         <= it.delta_h;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_item(it);
  endtask

  function automatic cell_item_t make_load(logic [4:0] slot, logic signed [15:0] w,
                                           logic signed [15:0] h);
    cell_item_t it = '0;
    it.action          = ACT_LOAD;
    it.template_index  = slot;
    it.template_width  = w;
    it.template_height = h;
    loaded[slot]       = 1'b1;
    return it;
  endfunction

  function automatic cell_item_t make_decode(logic [4:0] slot, logic [8:0] x, logic [8:0] y,
                                             logic [15:0] conf,
                                             logic signed [15:0] dx, logic signed [15:0] dy,
                                             logic signed [15:0] dw, logic signed [15:0] dh);
    cell_item_t it = '0;
    it.action         = ACT_DECODE;
    it.template_index = slot;
    it.cell_x         = x;
    it.cell_y         = y;
    it.confidence     = conf;
    it.delta_x        = dx;
    it.delta_y        = dy;
    it.delta_w        = dw;
    it.delta_h        = dh;
    return it;
  endfunction

  // Decodes only ever use slots that were loaded
  function automatic logic [4:0] pick_slot();
    logic [4:0] s;
    do s = 5'($urandom_range(0, TEMPLATE_SLOTS - 1)); while (!loaded[s]);
    return s;
  endfunction

  // Mostly plausible boxes near the frame, some loads, the rest full-range noise
  function automatic cell_item_t random_item();
    cell_item_t it;
    int         pick, x_top, y_top;
    pick  = $urandom_range(0, 99);
    x_top = (sb.frame_w / 8 + 1 > 511) ? 511 : sb.frame_w / 8 + 1;
    y_top = (sb.frame_h / 8 + 1 > 511) ? 511 : sb.frame_h / 8 + 1;
    it.action          = ACT_DECODE;
    it.template_index  = pick_slot();
    it.template_width  = 16'($urandom);
    it.template_height = 16'($urandom);
    it.cell_x          = 9'($urandom);
    it.cell_y          = 9'($urandom);
    it.confidence      = 16'($urandom);
    it.delta_x         = 16'($urandom);
    it.delta_y         = 16'($urandom);
    it.delta_w         = 16'($urandom);
    it.delta_h         = 16'($urandom);
    if (pick < 15) begin
      it.action         = ACT_LOAD;
      it.template_index = 5'($urandom_range(0, TEMPLATE_SLOTS - 1));
      if (pick >= 3) begin
        it.template_width  = 16'($urandom_range(32, 2048));
        it.template_height = 16'($urandom_range(32, 2048));
      end
      loaded[it.template_index] = 1'b1;
    end else if (pick < 85) begin
      it.cell_x  = 9'($urandom_range(0, x_top));
      it.cell_y  = 9'($urandom_range(0, y_top));
      it.delta_x = 16'(int'($urandom_range(0, 4096)) - 2048);
      it.delta_y = 16'(int'($urandom_range(0, 4096)) - 2048);
      it.delta_w = 16'(int'($urandom_range(0, 8192)) - 4096);
      it.delta_h = 16'(int'($urandom_range(0, 8192)) - 4096);
      if (pick < 80) it.confidence = 16'($urandom_range(sb.threshold, 16'hFFFF));
    end
    return it;
  endfunction

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 149) == 0) wait_drained();
      send_item(random_item());
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_ch.valid           = 1'b0;
    in_ch.action          = ACT_LOAD;
    in_ch.template_index  = '0;
    in_ch.template_width  = '0;
    in_ch.template_height = '0;
    in_ch.cell_x          = '0;
    in_ch.cell_y          = '0;
    in_ch.confidence      = '0;
    in_ch.delta_x         = '0;
    in_ch.delta_y         = '0;
    in_ch.delta_w         = '0;
    in_ch.delta_h         = '0;
    out_ch.ready          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    readback_regs();

    configure(16'h1000, 12'd224, 12'd224);
    gaps_on = 1'b1;
    send_item(make_load(5'd0, 16'sd256, 16'sd256));
    send_item(make_load(5'd1, 16'sh8000, -16'sd16));
    send_item(make_load(5'd2, 16'sd0, 16'sd0));
    send_item(make_load(5'd3, 16'sd512, 16'sd384));
    send_item(make_load(5'd31, 16'sh7FFF, 16'sh7FFF));
    send_item(make_decode(5'd0, 9'd10, 9'd10, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    // just under and exactly at the threshold
    send_item(make_decode(5'd0, 9'd10, 9'd10, 16'h0FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_decode(5'd0, 9'd10, 9'd10, 16'h1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    // negative template gives negative size; zero template keeps a point box
    send_item(make_decode(5'd1, 9'd10, 9'd10, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_decode(5'd2, 9'd10, 9'd10, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    // frame edges: left/top off, right edge just inside, right and bottom off
    send_item(make_decode(5'd0, 9'd0, 9'd0, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_decode(5'd0, 9'd2, 9'd2, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_decode(5'd0, 9'd27, 9'd27, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_decode(5'd0, 9'd28, 9'd13, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_decode(5'd0, 9'd13, 9'd28, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_decode(5'd0, 9'd511, 9'd511, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    // saturating size
    send_item(make_decode(5'd31, 9'd10, 9'd10, 16'hFFFF, 16'sd0, 16'sd0, 16'sh7FFF,
                          16'sh7FFF));
    // delta extremes
    send_item(make_decode(5'd3, 9'd12, 9'd12, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sd0,
                          16'sd0));
    send_item(make_decode(5'd3, 9'd12, 9'd12, 16'hFFFF, 16'sd0, 16'sd0, 16'sh8000,
                          16'sh8000));
    send_item(make_decode(5'd3, 9'd14, 9'd14, 16'hFFFF, 16'sh1000, -16'sh1000, 16'sh1000,
                          -16'sh1000));
    send_item(make_decode(5'd0, 9'd14, 9'd14, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0));

    configure(16'($urandom_range(0, 16'h4000)), 12'($urandom_range(64, 640)),
              12'($urandom_range(64, 640)));
    run_random(150);
    configure(16'h0000, 12'd4095, 12'd4095);
    run_random(150);
    configure(16'hFFFF, 12'd1, 12'd1);
    run_random(60);
    configure(16'($urandom_range(0, 16'h8000)), 12'($urandom_range(1, 4095)),
              12'($urandom_range(1, 4095)));
    run_random(160);
    configure(16'($urandom_range(0, 16'h2000)), 12'd320, 12'd240);
    gaps_on = 1'b0;
    run_random(160);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Summary: %0d items (%0d template loads, %0d cell decodes), %0d boxes checked",
             sb.loads + sb.decodes, sb.loads, sb.decodes, sb.boxes_seen);
    $display("Summary: %0d register settings, frames 1x1 to 4095x4095, %0d failures",
             settings_used, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
